/* hw/rtl/msort_pkg.sv */
// shared types and constants of the merge sorter
`default_nettype none

package msort_pkg;

  // width of one element
  localparam int DATA_W = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_en;    // write the incoming element into the source bank
    logic run_start;  // open a merge of two runs
    logic step;       // move one element of the current merge
    logic flip;       // swap source and destination banks
    logic emit_rd;    // read the element at the emit address
    logic emit_load;  // move the read element into the output register
    logic emit_last;  // marks the final element of the batch
    logic emit_ovf;   // the batch dropped elements
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic run_last_step;  // the current step writes the final element of the run
    logic out_free;       // output register can take an item this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/msort_if.sv */
// valid/ready channel interfaces for the input and result items
`default_nettype none

interface msort_in_if
  import msort_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;
  logic              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface msort_out_if
  import msort_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sorted_value;
  logic              is_last;
  logic              overflow;

  modport source (output valid, output sorted_value, output is_last, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input is_last, input overflow,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/msort_datapath.sv */
// element banks, merge pointers, head registers and output register
`default_nettype none

module msort_datapath
  import msort_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0] addr,
  input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0] run_lo,
  input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0] run_mid,
  input  wire logic [$clog2(MAX_ELEMENTS+1)-1:0] run_hi,
  input  wire logic [DATA_W-1:0] load_value,
  output dp_stat_t               stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      out_sorted_value,
  output logic                   out_is_last,
  output logic                   out_overflow
);

  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS+1);

  // two banks, used alternately as source and destination of a pass
  logic [DATA_W-1:0] mem0 [MAX_ELEMENTS];
  logic [DATA_W-1:0] mem1 [MAX_ELEMENTS];

  logic              bank_r;
  logic [CW-1:0]     a_r, b_r, k_r, mid_r, hi_r;
  logic [DATA_W-1:0] ha_r, hb_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r;
  logic              out_ovf_r;

  logic              take_a;
  logic [DATA_W-1:0] chosen;
  logic [CW-1:0]     rd_a_addr, rd_b_addr;
  logic              rd_en;
  logic              wr0_en, wr1_en;
  logic [CW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  // left-first merge decision keeps equal values in arrival order
  assign take_a = (a_r < mid_r) &&
                  ((b_r >= hi_r) || ($signed(ha_r) <= $signed(hb_r)));
  assign chosen = take_a ? ha_r : hb_r;

  // read addresses: heads of both runs, or the element to emit
  always_comb begin
    rd_a_addr = addr;
    rd_b_addr = b_r;
    if (cmd.run_start) begin
      rd_a_addr = run_lo;
      rd_b_addr = run_mid;
    end else if (cmd.step) begin
      rd_a_addr = take_a ? a_r + 1'b1 : a_r;
      rd_b_addr = take_a ? b_r : b_r + 1'b1;
    end
  end

  assign rd_en = cmd.run_start | cmd.step | cmd.emit_rd;

  // loads go to the source bank, merge output to the other one
  assign wr0_en  = (cmd.load_en && !bank_r) || (cmd.step && bank_r);
  assign wr1_en  = (cmd.load_en && bank_r) || (cmd.step && !bank_r);
  assign wr_addr = cmd.load_en ? addr : k_r;
  assign wr_data = cmd.load_en ? load_value : chosen;

  // bank writes
  always_ff @(posedge clk) begin
    if (wr0_en) begin
      mem0[wr_addr[IW-1:0]] <= wr_data;
    end
    if (wr1_en) begin
      mem1[wr_addr[IW-1:0]] <= wr_data;
    end
  end

  // registered head reads from the source bank
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ha_r <= bank_r ? mem1[rd_a_addr[IW-1:0]] : mem0[rd_a_addr[IW-1:0]];
      hb_r <= bank_r ? mem1[rd_b_addr[IW-1:0]] : mem0[rd_b_addr[IW-1:0]];
    end
  end

  // bank select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (cmd.flip) begin
      bank_r <= ~bank_r;
    end
  end

  // merge pointers
  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      a_r   <= run_lo;
      b_r   <= run_mid;
      k_r   <= run_lo;
      mid_r <= run_mid;
      hi_r  <= run_hi;
    end else if (cmd.step) begin
      k_r <= k_r + 1'b1;
      if (take_a) begin
        a_r <= a_r + 1'b1;
      end else begin
        b_r <= b_r + 1'b1;
      end
    end
  end

  assign stat.run_last_step = (({1'b0, k_r} + 1'b1) == {1'b0, hi_r});
  assign stat.out_free      = !out_valid_r || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_value_r <= ha_r;
      out_last_r  <= cmd.emit_last;
      out_ovf_r   <= cmd.emit_ovf;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_is_last      = out_last_r;
  assign out_overflow     = out_ovf_r;

endmodule

`default_nettype wire

/* hw/rtl/msort_ctrl.sv */
// batch sequencer: loading, merge passes and emission
`default_nettype none

module msort_ctrl
  import msort_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_last,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0] addr,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0] run_lo,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0] run_mid,
  output logic [$clog2(MAX_ELEMENTS+1)-1:0] run_hi
);

  localparam int CW = $clog2(MAX_ELEMENTS+1);
  // headroom for run width doubling past the count and lo + 2 * width
  localparam int SW = CW + 3;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RUN_START,
    S_RUN_STEP,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic [SW-1:0] width_r, width_nxt;
  logic [SW-1:0] lo_r, lo_nxt;

  logic          full;
  logic [SW-1:0] n_ext;
  logic [SW-1:0] mid_calc, hi_calc, lo_adv, width_dbl;

  assign full      = (fill_r == CW'(MAX_ELEMENTS));
  assign n_ext     = SW'(n_r);
  assign width_dbl = width_r << 1;
  assign lo_adv    = lo_r + width_dbl;
  assign mid_calc  = ((lo_r + width_r) > n_ext) ? n_ext : lo_r + width_r;
  assign hi_calc   = (lo_adv > n_ext) ? n_ext : lo_adv;

  assign in_ready = (state_r == S_LOAD);
  assign run_lo   = lo_r[CW-1:0];
  assign run_mid  = mid_calc[CW-1:0];
  assign run_hi   = hi_calc[CW-1:0];
  assign addr     = (state_r == S_LOAD) ? fill_r : e_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    e_nxt     = e_r;
    width_nxt = width_r;
    lo_nxt    = lo_r;
    cmd       = '0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load_en = !full;
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + 1'b1;
          end
          if (in_last) begin
            n_nxt     = full ? fill_r : fill_r + 1'b1;
            width_nxt = SW'(1);
            lo_nxt    = '0;
            e_nxt     = '0;
            state_nxt = (n_nxt > CW'(1)) ? S_RUN_START : S_EMIT_RD;
          end
        end
      end
      S_RUN_START: begin
        cmd.run_start = 1'b1;
        state_nxt     = S_RUN_STEP;
      end
      S_RUN_STEP: begin
        cmd.step = 1'b1;
        if (stat.run_last_step) begin
          if (lo_adv >= n_ext) begin
            // pass complete
            cmd.flip  = 1'b1;
            width_nxt = width_dbl;
            lo_nxt    = '0;
            state_nxt = (width_dbl >= n_ext) ? S_EMIT_RD : S_RUN_START;
          end else begin
            lo_nxt    = lo_adv;
            state_nxt = S_RUN_START;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.emit_last = (({1'b0, e_r} + 1'b1) == {1'b0, n_r});
        cmd.emit_ovf  = ovf_r;
        if (stat.out_free) begin
          cmd.emit_load = 1'b1;
          if (cmd.emit_last) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            e_nxt     = e_r + 1'b1;
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      n_r     <= '0;
      e_r     <= '0;
      width_r <= '0;
      lo_r    <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
      n_r     <= n_nxt;
      e_r     <= e_nxt;
      width_r <= width_nxt;
      lo_r    <= lo_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/merge_sorter.sv */
// top level of the batch merge sorter
//
// Sorts one batch of up to MAX_ELEMENTS signed 32-bit values ascending,
// stable for equal values. Items are taken one per cycle while loading; the
// item with last set closes the batch, and from then on in_ch.ready stays low
// until the final sorted item has been moved into the output register. Sorting
// is a bottom-up merge between two element banks: ceil(log2 n) passes, each
// opening its runs in turn and moving every element once, by the single merge
// step per cycle. Each item is emitted as one bank read followed by one output
// register load, and the load waits until the output register is free. Values
// beyond capacity are dropped and every result of that batch carries
// overflow.
`default_nettype none

module merge_sorter
  import msort_pkg::*;
#(
  parameter int MAX_ELEMENTS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  msort_in_if.sink    in_ch,
  msort_out_if.source out_ch
);

  localparam int CW = $clog2(MAX_ELEMENTS+1);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [CW-1:0] addr;
  logic [CW-1:0] run_lo, run_mid, run_hi;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  // sequencer
  msort_ctrl #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd),
    .addr     (addr),
    .run_lo   (run_lo),
    .run_mid  (run_mid),
    .run_hi   (run_hi)
  );

  // storage and merge datapath
  msort_datapath #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .addr             (addr),
    .run_lo           (run_lo),
    .run_mid          (run_mid),
    .run_hi           (run_hi),
    .load_value       (in_ch.value),
    .stat             (stat),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_sorted_value (out_ch.sorted_value),
    .out_is_last      (out_ch.is_last),
    .out_overflow     (out_ch.overflow)
  );

  // at most one datapath operation per cycle
  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_en, cmd.run_start, cmd.step, cmd.emit_rd, cmd.emit_load}))
    else $error("more than one datapath operation in a cycle");

  // every opened run moves at least one element next
  a_start_then_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run_start |=> cmd.step)
    else $error("run opened without a merge step");

  // final result of a batch reopens the input
  a_last_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_load && cmd.emit_last) |=> in_ch.ready)
    else $error("input not ready after final result");

  // input not ready during a merge step or an emit read of a batch
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step || cmd.emit_rd) |-> !in_ch.ready)
    else $error("input ready while batch busy");

endmodule

`default_nettype wire

/* tb/sv/merge_sorter_test.sv */
// testbench of the merge sorter: directed and random batches checked against a sorting predictor
`default_nettype none

module merge_sorter_test;
  import msort_pkg::*;

  localparam int CAPACITY      = 32;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;
  localparam int REPORT_LINES  = 50;

  typedef logic signed [DATA_W-1:0] elem_t;

  localparam elem_t VAL_MAX = 32'h7FFF_FFFF;
  localparam elem_t VAL_MIN = 32'h8000_0000;

  // one expected sorted item
  typedef struct {
    elem_t value;
    logic  is_last;
    logic  overflow;
  } sorted_item_t;

  logic clk;
  logic rst_n;

  msort_in_if  in_if ();
  msort_out_if out_if ();

  merge_sorter #(
    .MAX_ELEMENTS(CAPACITY)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // predictor state: the open batch and the sorted items still owed
  elem_t        batch_values[$];
  logic         batch_overflow;
  sorted_item_t sorted_expect[$];

  int fail_count;
  int items_sent;
  int cycle_count;
  int send_idle_pct;
  int recv_idle_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // count a mismatch, print a bounded number of them
  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= REPORT_LINES) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
  endtask

  // store an accepted element; on the closing item queue the sorted batch
  task automatic absorb_element(input elem_t v, input logic lst);
    elem_t ordered[$];
    elem_t key;
    int    i;
    int    j;
    if (batch_values.size() < CAPACITY) begin
      batch_values.push_back(v);
    end else begin
      batch_overflow = 1'b1;
    end
    if (lst) begin
      ordered = batch_values;
      // insertion sort, strict compare keeps equal values in arrival order
      for (i = 1; i < ordered.size(); i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = key;
      end
      for (i = 0; i < ordered.size(); i++) begin
        sorted_expect.push_back('{value: ordered[i], is_last: (i == ordered.size() - 1),
                                  overflow: batch_overflow});
      end
      batch_values.delete();
      batch_overflow = 1'b0;
    end
  endtask

  // drive one item, idling first at random; called and left at a falling edge
  task automatic send_element(input elem_t v, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    in_if.last  <= lst;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    absorb_element(v, lst);
    items_sent++;
    @(negedge clk);
  endtask

  // hold off the sender until every owed item has come back
  task automatic pause_until_drained();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (sorted_expect.size() != 0) @(negedge clk);
  endtask

  // mix of full-range values, clustered small values and extremes
  function automatic elem_t random_element();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return elem_t'($urandom);
      6, 7: return elem_t'($urandom_range(15)) - 8;
      8: begin
        case ($urandom_range(3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return elem_t'($urandom_range(1000)) - 500;
    endcase
  endfunction

  // mostly short batches, some longer ones up to capacity, a few that overflow
  function automatic int random_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return $urandom_range(6, 1);
    if (pick < 85) return $urandom_range(16, 7);
    if (pick < 95) return $urandom_range(CAPACITY, 17);
    return $urandom_range(CAPACITY + 8, CAPACITY + 1);
  endfunction

  task automatic send_list(input elem_t vals[$]);
    int k;
    for (k = 0; k < vals.size(); k++) begin
      send_element(vals[k], k == vals.size() - 1);
    end
  endtask

  task automatic send_random_batch(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_element(random_element(), k == len - 1);
    end
  endtask

  // single-element batches, extremes, duplicates, reversed and sorted input
  task automatic test_directed();
    send_list('{VAL_MIN});
    send_list('{VAL_MAX});
    send_list('{VAL_MAX, VAL_MIN, 0, -1, 1});
    send_list('{7, -2, 7, -2, 0, 7});
    send_list('{40, 30, 20, 10, 0, -10});
    send_list('{-5, 5});
    pause_until_drained();
  endtask

  // exactly full, dropped item closing the batch, several dropped items
  task automatic test_capacity();
    send_random_batch(CAPACITY);
    send_random_batch(CAPACITY + 1);
    send_random_batch(CAPACITY + 4);
    pause_until_drained();
  endtask

  task automatic test_random(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      send_random_batch(random_length());
    end
    pause_until_drained();
  endtask

  // receiver stalls at random
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare each accepted result with the oldest owed item
  always @(posedge clk) begin : check_results
    sorted_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (sorted_expect.size() == 0) begin
        report_mismatch($sformatf("unexpected item, value %0d",
                                  $signed(out_if.sorted_value)));
      end else begin
        want = sorted_expect.pop_front();
        if (out_if.sorted_value !== want.value) begin
          report_mismatch($sformatf("sorted_value %0d, wanted %0d",
                                    $signed(out_if.sorted_value), want.value));
        end
        if (out_if.is_last !== want.is_last) begin
          report_mismatch($sformatf("is_last %b, wanted %b", out_if.is_last, want.is_last));
        end
        if (out_if.overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow %b, wanted %b", out_if.overflow,
                                    want.overflow));
        end
      end
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // test sequence
  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.value    = '0;
    in_if.last     = 1'b0;
    out_if.ready   = 1'b0;
    batch_overflow = 1'b0;
    fail_count     = 0;
    items_sent     = 0;
    send_idle_pct  = 32;
    recv_idle_pct  = 75;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // sender idles lightly, receiver heavily
    test_directed();
    test_random(90);

    // the other way round
    send_idle_pct = 75;
    recv_idle_pct = 32;
    test_capacity();
    test_random(90);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(90);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && sorted_expect.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
